// ===== src/hed_pkg.sv =====
package hed_pkg;

  // Byte codes the decoder looks for
  localparam logic [7:0] CH_AMP   = 8'h26;  // '&'
  localparam logic [7:0] CH_SEMI  = 8'h3B;  // ';'
  localparam logic [7:0] CH_HASH  = 8'h23;  // '#'
  localparam logic [7:0] CH_SPACE = 8'h20;  // highest terminator below 0x80
  localparam logic [7:0] CH_HIGH  = 8'h80;  // lowest terminator at the top
  localparam logic [7:0] CH_GT    = 8'h3E;  // '>'
  localparam logic [7:0] CH_LT    = 8'h3C;  // '<'
  localparam logic [7:0] CH_QUOTE = 8'h22;  // '"'
  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE  = 8'h39;  // '9'

  // Letters of the known names
  localparam logic [7:0] CH_G = 8'h67;
  localparam logic [7:0] CH_L = 8'h6C;
  localparam logic [7:0] CH_T = 8'h74;
  localparam logic [7:0] CH_Q = 8'h71;
  localparam logic [7:0] CH_U = 8'h75;
  localparam logic [7:0] CH_O = 8'h6F;

  // Output sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_NAME,
    S_SEMI,
    S_TERM
  } hed_state_t;

endpackage

// ===== src/html_entity_decoder.sv =====
// HTML entity decoder.
// The input channel carries one text byte per word plus in_last, which
// marks the final byte of a text. The output channel carries decoded bytes;
// out_run_end marks the last word caused by one input word, out_stream_end
// the last word of the text, and a word with out_byte_valid low is an
// end marker that carries no byte.
// Plain bytes, name bytes and known or numeric names closed by ';' need no
// replay, so the input is stalled for them only by out_stall; a known or
// numeric name closed by a space, control or high byte also stalls the input
// while that byte follows the replacement. The first output word is formed
// in the cycle the input is taken and is registered onto the output.
// An unknown name or an over-long name is replayed verbatim from the name
// buffer, one word per cycle while the output is not stalled, a pace set by
// the single read port of the name buffer; the input stays stalled during
// that replay.
// Reset returns the block to plain text mode with the output empty; the
// name buffer is not cleared. While out_stall is high on a valid output word,
// that word holds and the input is stalled; no word is lost or repeated.
module html_entity_decoder import hed_pkg::*; #(
  parameter int MAX_NAME = 15
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_byte_valid,
  output logic       out_run_end,
  output logic       out_stream_end,
  output logic       out_name_overflow
);

  localparam int AW = $clog2(MAX_NAME);
  localparam int CW = $clog2(MAX_NAME + 1);

  // Entity state
  logic          in_entity_r, in_entity_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [7:0]    acc_r, acc_nxt;
  logic          stopped_r, stopped_nxt;
  logic          hash_r, hash_nxt;
  logic          m_gt_r, m_gt_nxt;
  logic          m_lt_r, m_lt_nxt;
  logic          m_quot_r, m_quot_nxt;

  // Replay plan
  hed_state_t    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic          semi_r, semi_nxt;
  logic          term_r, term_nxt;
  logic          ovf_r, ovf_nxt;
  logic          last_r, last_nxt;
  logic [7:0]    term_byte_r, term_byte_nxt;

  // Output register
  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_bv_r, out_run_r, out_str_r, out_ovf_r;

  // Generated word
  logic       gen_valid;
  logic [7:0] gen_byte;
  logic       gen_bv, gen_run, gen_str, gen_ovf;

  // Name buffer ports
  logic          wr_en, rd_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;

  logic          out_free, accept;
  logic          is_semi, is_term, is_digit, overflow, name_last;
  logic          known_gt, known_lt, known_quot;
  logic [7:0]    acc_step;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !(state_r == S_IDLE && out_free);
  assign accept   = in_valid && !in_stall;

  // Classify the input byte
  assign is_semi  = (in_byte == CH_SEMI);
  assign is_term  = (in_byte <= CH_SPACE) || (in_byte >= CH_HIGH);
  assign is_digit = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
  assign overflow = (count_r >= CW'(MAX_NAME));
  assign acc_step = 8'(acc_r * 8'd10 + (in_byte - CH_ZERO));

  assign known_gt   = m_gt_r && (count_r == CW'(2));
  assign known_lt   = m_lt_r && (count_r == CW'(2));
  assign known_quot = m_quot_r && (count_r == CW'(4));

  assign name_last = (CW'(idx_r) == cnt_r - CW'(1));

  hed_name_mem #(
    .DEPTH (MAX_NAME)
  ) u_name_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[AW-1:0]),
    .wr_data (in_byte),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Decode, plan the replay and drive the next output word
  always_comb begin
    state_nxt     = state_r;
    in_entity_nxt = in_entity_r;
    count_nxt     = count_r;
    acc_nxt       = acc_r;
    stopped_nxt   = stopped_r;
    hash_nxt      = hash_r;
    m_gt_nxt      = m_gt_r;
    m_lt_nxt      = m_lt_r;
    m_quot_nxt    = m_quot_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    semi_nxt      = semi_r;
    term_nxt      = term_r;
    ovf_nxt       = ovf_r;
    last_nxt      = last_r;
    term_byte_nxt = term_byte_r;
    gen_valid     = 1'b0;
    gen_byte      = 8'h00;
    gen_bv        = 1'b0;
    gen_run       = 1'b0;
    gen_str       = 1'b0;
    gen_ovf       = 1'b0;
    wr_en         = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = idx_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          last_nxt      = in_last;
          term_byte_nxt = in_byte;
          if (!in_entity_r) begin
            if (in_byte != CH_AMP) begin
              // pass a plain byte
              gen_valid = 1'b1;
              gen_byte  = in_byte;
              gen_bv    = 1'b1;
              gen_run   = 1'b1;
            end else begin
              // open a name
              in_entity_nxt = 1'b1;
              count_nxt     = '0;
              acc_nxt       = '0;
              stopped_nxt   = 1'b0;
              hash_nxt      = 1'b0;
              m_gt_nxt      = 1'b0;
              m_lt_nxt      = 1'b0;
              m_quot_nxt    = 1'b0;
            end
          end else if (is_semi || is_term) begin
            // resolve the name
            gen_valid = 1'b1;
            gen_bv    = 1'b1;
            semi_nxt  = is_semi;
            term_nxt  = is_term;
            ovf_nxt   = 1'b0;
            cnt_nxt   = count_r;
            idx_nxt   = '0;
            priority if (hash_r || known_gt || known_lt || known_quot) begin
              priority if (hash_r) gen_byte = acc_r;
              else if (known_gt)   gen_byte = CH_GT;
              else if (known_lt)   gen_byte = CH_LT;
              else                 gen_byte = CH_QUOTE;
              gen_run = !is_term;
              if (is_term) state_nxt = S_TERM;
            end else begin
              gen_byte = CH_AMP;
              if (count_r != '0) begin
                state_nxt = S_NAME;
                rd_en     = 1'b1;
                rd_addr   = '0;
              end else if (is_semi) begin
                state_nxt = S_SEMI;
              end else begin
                state_nxt = S_TERM;
              end
            end
            in_entity_nxt = 1'b0;
          end else if (overflow) begin
            // flush the over-long name verbatim
            gen_valid     = 1'b1;
            gen_byte      = CH_AMP;
            gen_bv        = 1'b1;
            gen_ovf       = 1'b1;
            semi_nxt      = 1'b0;
            term_nxt      = 1'b1;
            ovf_nxt       = 1'b1;
            cnt_nxt       = count_r;
            idx_nxt       = '0;
            state_nxt     = S_NAME;
            rd_en         = 1'b1;
            rd_addr       = '0;
            in_entity_nxt = 1'b0;
          end else begin
            // append a name byte
            wr_en     = 1'b1;
            count_nxt = count_r + CW'(1);
            if (count_r == '0) begin
              hash_nxt   = (in_byte == CH_HASH);
              m_gt_nxt   = (in_byte == CH_G);
              m_lt_nxt   = (in_byte == CH_L);
              m_quot_nxt = (in_byte == CH_Q);
            end else begin
              m_gt_nxt   = m_gt_r && (count_r == CW'(1)) && (in_byte == CH_T);
              m_lt_nxt   = m_lt_r && (count_r == CW'(1)) && (in_byte == CH_T);
              priority if (count_r == CW'(1)) m_quot_nxt = m_quot_r && (in_byte == CH_U);
              else if (count_r == CW'(2))     m_quot_nxt = m_quot_r && (in_byte == CH_O);
              else if (count_r == CW'(3))     m_quot_nxt = m_quot_r && (in_byte == CH_T);
              else                            m_quot_nxt = 1'b0;
            end
            if (hash_r && !stopped_r) begin
              if (is_digit) acc_nxt = acc_step;
              else          stopped_nxt = 1'b1;
            end
          end

          // end of text: drop any open name, mark an empty run
          if (in_last) begin
            in_entity_nxt = 1'b0;
            count_nxt     = '0;
            acc_nxt       = '0;
            stopped_nxt   = 1'b0;
            if (!gen_valid) begin
              gen_valid = 1'b1;
              gen_run   = 1'b1;
            end
          end
          gen_str = in_last && gen_run;
        end
      end

      S_NAME: begin
        gen_valid = 1'b1;
        gen_byte  = rd_data;
        gen_bv    = 1'b1;
        gen_ovf   = ovf_r;
        gen_run   = name_last && !semi_r && !term_r;
        gen_str   = last_r && gen_run;
        if (out_free) begin
          if (!name_last) begin
            idx_nxt = idx_r + AW'(1);
            rd_en   = 1'b1;
            rd_addr = idx_r + AW'(1);
          end else if (semi_r) begin
            state_nxt = S_SEMI;
          end else if (term_r) begin
            state_nxt = S_TERM;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end

      S_SEMI: begin
        gen_valid = 1'b1;
        gen_byte  = CH_SEMI;
        gen_bv    = 1'b1;
        gen_run   = 1'b1;
        gen_str   = last_r;
        if (out_free) state_nxt = S_IDLE;
      end

      S_TERM: begin
        gen_valid = 1'b1;
        gen_byte  = term_byte_r;
        gen_bv    = 1'b1;
        gen_ovf   = ovf_r;
        gen_run   = 1'b1;
        gen_str   = last_r;
        if (out_free) state_nxt = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_entity_r <= 1'b0;
      count_r     <= '0;
      acc_r       <= '0;
      stopped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_entity_r <= in_entity_nxt;
      count_r     <= count_nxt;
      acc_r       <= acc_nxt;
      stopped_r   <= stopped_nxt;
      if (gen_valid && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Name flags, replay plan and output word
  always_ff @(posedge clk) begin
    hash_r      <= hash_nxt;
    m_gt_r      <= m_gt_nxt;
    m_lt_r      <= m_lt_nxt;
    m_quot_r    <= m_quot_nxt;
    cnt_r       <= cnt_nxt;
    idx_r       <= idx_nxt;
    semi_r      <= semi_nxt;
    term_r      <= term_nxt;
    ovf_r       <= ovf_nxt;
    last_r      <= last_nxt;
    term_byte_r <= term_byte_nxt;
    if (gen_valid && out_free) begin
      out_byte_r <= gen_byte;
      out_bv_r   <= gen_bv;
      out_run_r  <= gen_run;
      out_str_r  <= gen_str;
      out_ovf_r  <= gen_ovf;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_byte          = out_byte_r;
  assign out_byte_valid    = out_bv_r;
  assign out_run_end       = out_run_r;
  assign out_stream_end    = out_str_r;
  assign out_name_overflow = out_ovf_r;

endmodule

// ===== src/hed_name_mem.sv =====
module hed_name_mem import hed_pkg::*; #(
  parameter int DEPTH = 15
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [7:0]               wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [7:0]               rd_data
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_r;

  // Write one name byte
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read, held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== src/hed_checker.sv =====
module hed_checker import hed_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       out_byte_valid,
  input logic       out_run_end,
  input logic       out_stream_end,
  input logic       out_name_overflow
);

  // Hold a stalled output word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(out_run_end))
    else $error("stalled output word changed");

  // End marker carries no byte and closes both the run and the text
  a_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_byte_valid |-> out_byte == 8'h00 && out_run_end && out_stream_end)
    else $error("malformed end marker");

  // Text end only on a run end
  a_stream_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stream_end |-> out_run_end)
    else $error("text end without run end");

  // Overflow flush words always carry bytes
  a_ovf_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_name_overflow |-> out_byte_valid)
    else $error("overflow flag on a marker");

endmodule

bind html_entity_decoder hed_checker u_hed_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_byte          (out_byte),
  .out_byte_valid    (out_byte_valid),
  .out_run_end       (out_run_end),
  .out_stream_end    (out_stream_end),
  .out_name_overflow (out_name_overflow)
);

// ===== tb/html_entity_decoder_checker.sv =====
module html_entity_decoder_checker import hed_pkg::*; #(
  parameter int MAX_NAME = 15
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_byte,
  input  logic       out_byte_valid,
  input  logic       out_run_end,
  input  logic       out_stream_end,
  input  logic       out_name_overflow,
  output int         fail_count,
  output int         pending,
  output int         words_seen,
  output int         flush_words
);

  typedef struct packed {
    logic [7:0] data;
    logic       data_valid;
    logic       run_end;
    logic       stream_end;
    logic       overflow;
  } decoded_word_t;

  // Decoded words still owed by the block, oldest first
  decoded_word_t expected_words[$];
  // Words caused by the input word being decoded now
  decoded_word_t run_words[$];

  // Decoder state as the text so far implies it
  logic       in_name;
  logic [7:0] name_buf [MAX_NAME];
  int         name_len;
  logic [7:0] num_value;
  logic       num_done;

  task automatic emit(input logic [7:0] b, input logic valid, input logic ovf);
    decoded_word_t w;
    w.data       = b;
    w.data_valid = valid;
    w.run_end    = 1'b0;
    w.stream_end = 1'b0;
    w.overflow   = ovf;
    run_words.push_back(w);
  endtask

  task automatic clear_name();
    in_name   = 1'b0;
    name_len  = 0;
    num_value = 8'h00;
    num_done  = 1'b0;
  endtask

  // Replace a finished name, or replay it when it is not known
  task automatic resolve_name(input logic semi);
    if (name_len >= 1 && name_buf[0] == CH_HASH) begin
      emit(num_value, 1'b1, 1'b0);
    end else if (name_len == 2 && name_buf[0] == CH_G && name_buf[1] == CH_T) begin
      emit(CH_GT, 1'b1, 1'b0);
    end else if (name_len == 2 && name_buf[0] == CH_L && name_buf[1] == CH_T) begin
      emit(CH_LT, 1'b1, 1'b0);
    end else if (name_len == 4 && name_buf[0] == CH_Q && name_buf[1] == CH_U &&
                 name_buf[2] == CH_O && name_buf[3] == CH_T) begin
      emit(CH_QUOTE, 1'b1, 1'b0);
    end else begin
      emit(CH_AMP, 1'b1, 1'b0);
      for (int i = 0; i < name_len; i++) emit(name_buf[i], 1'b1, 1'b0);
      if (semi) emit(CH_SEMI, 1'b1, 1'b0);
    end
    clear_name();
  endtask

  // Work out every word one input word causes and queue them
  task automatic decode_word(input logic [7:0] b, input logic is_last);
    decoded_word_t w;
    run_words.delete();
    if (!in_name) begin
      if (b == CH_AMP) begin
        clear_name();
        in_name = 1'b1;
      end else begin
        emit(b, 1'b1, 1'b0);
      end
    end else if (b == CH_SEMI) begin
      resolve_name(1'b1);
    end else if (b <= CH_SPACE || b >= CH_HIGH) begin
      resolve_name(1'b0);
      emit(b, 1'b1, 1'b0);
    end else if (name_len >= MAX_NAME) begin
      // flush an over-long name verbatim, flagged
      emit(CH_AMP, 1'b1, 1'b1);
      for (int i = 0; i < MAX_NAME; i++) emit(name_buf[i], 1'b1, 1'b1);
      emit(b, 1'b1, 1'b1);
      clear_name();
    end else begin
      if (name_len >= 1 && name_buf[0] == CH_HASH && !num_done) begin
        if (b >= CH_ZERO && b <= CH_NINE) num_value = num_value * 8'd10 + (b - CH_ZERO);
        else num_done = 1'b1;
      end
      name_buf[name_len] = b;
      name_len++;
    end

    // drop an open entity at end of text; mark an end with no byte
    if (is_last) begin
      clear_name();
      if (run_words.size() == 0) emit(8'h00, 1'b0, 1'b0);
    end
    if (run_words.size() > 0) begin
      w = run_words.pop_back();
      w.run_end    = 1'b1;
      w.stream_end = is_last;
      run_words.push_back(w);
    end
    while (run_words.size() > 0) expected_words.push_back(run_words.pop_front());
  endtask

  task automatic report_mismatch(input string what, input decoded_word_t want,
                                 input decoded_word_t got);
    fail_count++;
    $display("MISMATCH %s: want %02h v%0b r%0b s%0b o%0b, got %02h v%0b r%0b s%0b o%0b",
             what, want.data, want.data_valid, want.run_end, want.stream_end,
             want.overflow, got.data, got.data_valid, got.run_end, got.stream_end,
             got.overflow);
  endtask

  // Compare taken output words first, then predict from the taken input word
  always @(posedge clk) begin
    decoded_word_t want;
    decoded_word_t got;
    if (!rst_n) begin
      clear_name();
      expected_words.delete();
      fail_count  = 0;
      words_seen  = 0;
      flush_words = 0;
    end else begin
      if (out_valid && !out_stall) begin
        got.data       = out_byte;
        got.data_valid = out_byte_valid;
        got.run_end    = out_run_end;
        got.stream_end = out_stream_end;
        got.overflow   = out_name_overflow;
        words_seen++;
        if (out_name_overflow === 1'b1) flush_words++;
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected word", '0, got);
        end else begin
          want = expected_words.pop_front();
          if (got !== want) report_mismatch("wrong word", want, got);
        end
      end
      if (in_valid && !in_stall) decode_word(in_byte, in_last);
    end
    pending <= expected_words.size();
  end

endmodule

// ===== tb/html_entity_decoder_tb.sv =====
module html_entity_decoder_tb;
  import hed_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASE_WORDS  = 70;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic [7:0] in_byte   = 8'h00;
  logic       in_last   = 1'b0;
  logic       out_stall = 1'b0;

  wire        in_stall;
  wire        out_valid;
  wire [7:0]  out_byte;
  wire        out_byte_valid;
  wire        out_run_end;
  wire        out_stream_end;
  wire        out_name_overflow;

  int fail_count;
  int pending;
  int words_seen;
  int flush_words;

  int gap_pct    = 0;
  int stall_pct  = 0;
  int words_sent = 0;
  int texts_sent = 0;
  int cycles     = 0;

  logic [7:0] text_bytes[$];

  always #6 clk = ~clk;

  html_entity_decoder u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_byte          (in_byte),
    .in_last          (in_last),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte         (out_byte),
    .out_byte_valid   (out_byte_valid),
    .out_run_end      (out_run_end),
    .out_stream_end   (out_stream_end),
    .out_name_overflow(out_name_overflow)
  );

  html_entity_decoder_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_byte          (in_byte),
    .in_last          (in_last),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte         (out_byte),
    .out_byte_valid   (out_byte_valid),
    .out_run_end      (out_run_end),
    .out_stream_end   (out_stream_end),
    .out_name_overflow(out_name_overflow),
    .fail_count       (fail_count),
    .pending          (pending),
    .words_seen       (words_seen),
    .flush_words      (flush_words)
  );

  // Stop a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Stall the output at the current phase's rate
  always @(posedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < stall_pct);
  end

  // Offer one word, idling first at random, and hold it until taken
  task automatic send_word(input logic [7:0] b, input logic is_last);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    in_last  <= is_last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
  endtask

  // Send the built text with in_last on its final byte
  task automatic send_text();
    for (int i = 0; i < text_bytes.size(); i++)
      send_word(text_bytes[i], i == text_bytes.size() - 1);
    text_bytes.delete();
    texts_sent++;
  endtask

  task automatic add_chars(input string s);
    for (int i = 0; i < s.len(); i++) text_bytes.push_back(s[i]);
  endtask

  // Any byte that stays inside a name
  function automatic logic [7:0] name_char();
    logic [7:0] c;
    c = 8'($urandom_range(8'h21, 8'h7F));
    if (c == CH_SEMI) c = 8'h7A;
    return c;
  endfunction

  // A byte that ends a name without being consumed
  function automatic logic [7:0] term_char();
    if ($urandom_range(1)) return 8'($urandom_range(8'h00, CH_SPACE));
    return 8'($urandom_range(CH_HIGH, 8'hFF));
  endfunction

  task automatic end_name();
    if ($urandom_range(2) != 0) text_bytes.push_back(CH_SEMI);
    else text_bytes.push_back(term_char());
  endtask

  // Append one piece of text: mostly well-formed entities, some noise
  task automatic add_segment();
    logic [7:0] c;
    int         n;
    case ($urandom_range(9))
      0, 1: begin
        n = $urandom_range(1, 4);
        repeat (n) begin
          c = 8'($urandom_range(255));
          if (c == CH_AMP) c = 8'h41;
          text_bytes.push_back(c);
        end
      end
      2: begin
        text_bytes.push_back(CH_AMP);
        case ($urandom_range(2))
          0: add_chars("gt");
          1: add_chars("lt");
          default: add_chars("quot");
        endcase
        end_name();
      end
      3, 4: begin
        text_bytes.push_back(CH_AMP);
        text_bytes.push_back(CH_HASH);
        n = $urandom_range(0, 6);
        repeat (n) text_bytes.push_back(8'($urandom_range(CH_ZERO, CH_NINE)));
        if ($urandom_range(2) == 0) begin
          text_bytes.push_back(name_char());
          text_bytes.push_back(8'($urandom_range(CH_ZERO, CH_NINE)));
        end
        end_name();
      end
      5, 6: begin
        text_bytes.push_back(CH_AMP);
        n = $urandom_range(0, 15);
        repeat (n) text_bytes.push_back(name_char());
        end_name();
      end
      7: begin
        // over-long name; bytes past the flush are plain text
        text_bytes.push_back(CH_AMP);
        n = $urandom_range(16, 18);
        repeat (n) text_bytes.push_back(name_char());
        if ($urandom_range(1)) end_name();
      end
      8: begin
        n = $urandom_range(1, 3);
        repeat (n) text_bytes.push_back(8'($urandom_range(255)));
      end
      default: begin
        text_bytes.push_back(CH_AMP);
        text_bytes.push_back(name_char());
        text_bytes.push_back(CH_AMP);
        text_bytes.push_back(name_char());
        end_name();
      end
    endcase
  endtask

  task automatic add_random_text();
    int n;
    n = $urandom_range(1, 6);
    repeat (n) add_segment();
    // leave an entity open at the end now and then
    if ($urandom_range(5) == 0) begin
      text_bytes.push_back(CH_AMP);
      n = $urandom_range(0, 3);
      repeat (n) text_bytes.push_back(name_char());
    end
  endtask

  initial begin
    int phase_start;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: byte extremes, known names, empty and numeric names,
    // ampersand inside a name, open entity at end, end with no byte
    text_bytes.push_back(8'h00);
    text_bytes.push_back(8'hFF);
    add_chars("&gt;&lt");
    text_bytes.push_back(CH_HIGH);
    add_chars("&quot;&;&#;&a&");
    text_bytes.push_back(CH_SPACE);
    send_text();
    add_chars("&x");
    send_text();
    add_chars("&");
    send_text();

    // Random texts under each idling pattern
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin gap_pct = 0;  stall_pct <= 0;  end
        1: begin gap_pct = 77; stall_pct <= 0;  end
        2: begin gap_pct = 0;  stall_pct <= 77; end
        default: begin gap_pct = 15; stall_pct <= 15; end
      endcase
      phase_start = words_sent;
      while (words_sent - phase_start < PHASE_WORDS) begin
        add_random_text();
        send_text();
      end
    end

    // Drain and watch for stray words
    in_valid  <= 1'b0;
    gap_pct    = 0;
    stall_pct <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d input words in %0d texts; checked %0d output words, %0d from flushes.",
             words_sent, texts_sent, words_seen, flush_words);
    $display("Idling patterns: none, sender 77%%, receiver 77%%, both 15%%.");
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
